@@ hw/rtl/mnemonic_checksum_validator_unit_defines.svh @@
// Assertion macros shared by the RTL.
`ifndef MNEMONIC_CHECKSUM_VALIDATOR_UNIT_DEFINES_SVH
`define MNEMONIC_CHECKSUM_VALIDATOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define MCV_ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define MCV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error("%m failed");
`else
`define MCV_ASSERT_IMPL(label, clk, rst_n, prop)
`define MCV_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hw/rtl/mcv_pkg.sv @@
package mcv_pkg;
  localparam int MAX_WORDS_DEF = 24;
  localparam int WORD_BITS = 11;
  localparam int STORE_BYTES = 33;
  localparam int STORE_BITS = STORE_BYTES * 8;

  localparam logic [1:0] ST_VALID    = 2'd0;
  localparam logic [1:0] ST_UNKNOWN  = 2'd1;
  localparam logic [1:0] ST_BADCOUNT = 2'd2;
  localparam logic [1:0] ST_MISMATCH = 2'd3;

  localparam logic [255:0] HASH_INIT = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    unique case (t)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  typedef struct packed {
    logic       start;
    logic [5:0] nbytes;
  } mcv_hash_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] top;
  } mcv_hash_rsp_t;
endpackage

@@ hw/rtl/mcv_sha_core.sv @@
// Single-block SHA-256, one round per cycle; returns top hash byte.
module mcv_sha_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mcv_pkg::mcv_hash_req_t req,
  input  logic [255:0]           msg,   // entropy bytes, byte 0 in top bits
  output mcv_pkg::mcv_hash_rsp_t rsp
);
  logic        busy_r, busy_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [5:0]  nb_r, nb_nxt;
  logic [31:0] v_r [8];
  logic [31:0] v_nxt [8];
  logic [31:0] w_r [16];
  logic [31:0] w_nxt [16];
  logic        done_r, done_nxt;
  logic [7:0]  top_r, top_nxt;

  logic [511:0] blk;
  logic [31:0]  w, g0, g1, s0, s1, ch, maj, t1, t2, w15, w2;
  logic [3:0]   ti;

  always_comb begin
    blk = {msg, 256'd0};
    for (int b = 0; b < 33; b++) begin
      if (b == int'(nb_r)) blk[511 - 8*b -: 8] = 8'h80;
      else if (b > int'(nb_r)) blk[511 - 8*b -: 8] = 8'h00;
    end
    blk[15:0] = {7'd0, nb_r, 3'd0};
  end

  always_comb begin
    ti  = rnd_r[3:0];
    w15 = w_r[4'(ti + 4'd1)];
    w2  = w_r[4'(ti + 4'd14)];
    g0  = {w15[6:0], w15[31:7]} ^ {w15[17:0], w15[31:18]} ^ (w15 >> 3);
    g1  = {w2[16:0], w2[31:17]} ^ {w2[18:0], w2[31:19]} ^ (w2 >> 10);
    if (!rnd_r[5] && !rnd_r[4]) w = blk[511 - 32*int'(ti) -: 32];
    else w = w_r[ti] + g0 + w_r[4'(ti + 4'd9)] + g1;
    s1  = {v_r[4][5:0], v_r[4][31:6]} ^ {v_r[4][10:0], v_r[4][31:11]}
        ^ {v_r[4][24:0], v_r[4][31:25]};
    ch  = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1  = v_r[7] + s1 + ch + mcv_pkg::round_k(rnd_r) + w;
    s0  = {v_r[0][1:0], v_r[0][31:2]} ^ {v_r[0][12:0], v_r[0][31:13]}
        ^ {v_r[0][21:0], v_r[0][31:22]};
    maj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2  = s0 + maj;
  end

  always_comb begin
    busy_nxt = busy_r;
    rnd_nxt  = rnd_r;
    nb_nxt   = nb_r;
    v_nxt    = v_r;
    w_nxt    = w_r;
    done_nxt = 1'b0;
    top_nxt  = top_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      rnd_nxt  = '0;
      nb_nxt   = req.nbytes;
      for (int i = 0; i < 8; i++) v_nxt[i] = mcv_pkg::HASH_INIT[255 - 32*i -: 32];
    end else if (busy_r) begin
      w_nxt[ti] = w;
      for (int i = 7; i > 0; i--) v_nxt[i] = v_r[i-1];
      v_nxt[4] = v_r[3] + t1;
      v_nxt[0] = t1 + t2;
      rnd_nxt  = rnd_r + 6'd1;
      if (rnd_r == 6'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        top_nxt  = 8'(((t1 + t2) + mcv_pkg::HASH_INIT[255:224]) >> 24);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      rnd_r  <= rnd_nxt;
    end
    nb_r  <= nb_nxt;
    v_r   <= v_nxt;
    w_r   <= w_nxt;
    top_r <= top_nxt;
  end

  assign rsp = {done_r, top_r};
endmodule

@@ hw/rtl/mnemonic_checksum_validator_unit.sv @@
// Path: the status beat follows the last word through S_START, the rounds of the single
// round unit in S_HASH and S_OUT when the hash runs, and through S_START and S_OUT alone
// when an unknown word or a bad count decides the status.
// Throughput: one word per cycle; input stalls from the last word until the status
// sits in the output register, and longer while an older status still waits there.
// Reset: synchronous active-low rst_n clears sequencer, counters, bit store, out valid.
`include "mnemonic_checksum_validator_unit_defines.svh"
module mnemonic_checksum_validator_unit #(
  parameter int MAX_WORDS = mcv_pkg::MAX_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,  // [10:0] word_id, [11] word_unknown
  input  logic        in_tlast,  // last_word
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata  // [1:0] status, [6:2] words_counted
);
  typedef enum logic [3:0] {
    S_COLLECT = 4'b0001,
    S_START   = 4'b0010,
    S_HASH    = 4'b0100,
    S_OUT     = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [mcv_pkg::STORE_BITS-1:0] store_r, store_nxt;   // bit 263 = first bit
  logic [4:0] cnt_r, cnt_nxt;
  logic       unk_r, unk_nxt;
  logic [1:0] status_r, status_nxt;
  logic       out_vld_r, out_vld_nxt;
  logic [6:0] out_dat_r, out_dat_nxt;  // {words_counted, status}
  logic [5:0] nbytes;
  logic [3:0] csb;
  logic [7:0] cs_byte;
  logic       acc, ok_cnt;
  mcv_pkg::mcv_hash_req_t req;
  mcv_pkg::mcv_hash_rsp_t rsp;

  assign in_tready  = (state_r == S_COLLECT);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, out_dat_r};
  assign acc = in_tvalid && in_tready;

  // entropy bytes = n*4/3, checksum bits = n/3 (narrow table)
  always_comb begin
    unique case (cnt_r)
      5'd12: begin nbytes = 6'd16; csb = 4'd4; end
      5'd15: begin nbytes = 6'd20; csb = 4'd5; end
      5'd18: begin nbytes = 6'd24; csb = 4'd6; end
      5'd21: begin nbytes = 6'd28; csb = 4'd7; end
      default: begin nbytes = 6'd32; csb = 4'd8; end
    endcase
  end
  assign ok_cnt = (cnt_r == 5'd12) || (cnt_r == 5'd15) || (cnt_r == 5'd18)
               || (cnt_r == 5'd21) || (cnt_r == 5'd24 && MAX_WORDS >= 24);
  // checksum byte follows the entropy
  assign cs_byte = store_r[mcv_pkg::STORE_BITS - 1 - 8*int'(nbytes) -: 8];

  assign req = {(state_r == S_START), nbytes};

  mcv_sha_core u_sha (
    .clk (clk), .rst_n (rst_n), .req (req),
    .msg (store_r[mcv_pkg::STORE_BITS-1 -: 256]), .rsp (rsp)
  );

  always_comb begin
    state_nxt   = state_r;
    store_nxt   = store_r;
    cnt_nxt     = cnt_r;
    unk_nxt     = unk_r;
    status_nxt  = status_r;
    // output register drains on its own handshake
    out_vld_nxt = out_vld_r && !out_tready;
    out_dat_nxt = out_dat_r;
    unique case (state_r)
      S_COLLECT: begin
        if (acc) begin
          if (int'(cnt_r) < MAX_WORDS) begin
            store_nxt[mcv_pkg::STORE_BITS - 1 - 11*int'(cnt_r) -: 11] = in_tdata[10:0];
            cnt_nxt = cnt_r + 5'd1;
            if (in_tdata[11]) unk_nxt = 1'b1;
          end
          if (in_tlast) state_nxt = S_START;
        end
      end
      S_START: begin
        if (unk_r) begin
          status_nxt = mcv_pkg::ST_UNKNOWN;
          state_nxt  = S_OUT;
        end else if (!ok_cnt) begin
          status_nxt = mcv_pkg::ST_BADCOUNT;
          state_nxt  = S_OUT;
        end else begin
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        if (rsp.done) begin
          status_nxt = ((rsp.top >> (4'd8 - csb)) == (cs_byte >> (4'd8 - csb)))
                     ? mcv_pkg::ST_VALID : mcv_pkg::ST_MISMATCH;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // load the status beat once the output register is free
        if (!out_vld_r || out_tready) begin
          out_vld_nxt = 1'b1;
          out_dat_nxt = {cnt_r, status_r};
          state_nxt   = S_COLLECT;
          store_nxt   = '0;
          cnt_nxt     = '0;
          unk_nxt     = 1'b0;
        end
      end
      default: state_nxt = S_COLLECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_COLLECT;
      store_r   <= '0;
      cnt_r     <= '0;
      unk_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      store_r   <= store_nxt;
      cnt_r     <= cnt_nxt;
      unk_r     <= unk_nxt;
      out_vld_r <= out_vld_nxt;
    end
    status_r  <= status_nxt;
    out_dat_r <= out_dat_nxt;
  end

  `MCV_ASSERT_IMPL(a_onehot, clk, rst_n, $onehot(state_r))
  `MCV_ASSERT_IMPL(a_cnt_cap, clk, rst_n, int'(cnt_r) <= MAX_WORDS)
  `MCV_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `MCV_ASSERT_NEXT(a_clear, clk, rst_n, (state_r == S_OUT) && (state_nxt == S_COLLECT), (cnt_r == 5'd0) && !unk_r && out_tvalid)
endmodule
